>>> hdl/cht_pkg.sv
// Shared types and constants for the capability handle table.
// Depends on nothing; the interfaces and the table unit import it.
`default_nettype none

package cht_pkg;

  localparam int CAP_W    = 9;   // capacity register and counters
  localparam int HANDLE_W = 16;  // handle field of a command word
  localparam int OUTH_W   = 8;   // handle field of a result word
  localparam int WORD_W   = 32;  // type and rights words
  localparam int HOST_W   = 64;  // host tag on the ports

  localparam logic [CAP_W-1:0] CAP_MAX   = {CAP_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REVOKE = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [WORD_W-1:0]   entry_type;
    logic [WORD_W-1:0]   entry_rights;
    logic [HOST_W-1:0]   host_tag;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [OUTH_W-1:0]   out_handle;
    logic [WORD_W-1:0]   out_type;
    logic [WORD_W-1:0]   out_rights;
    logic [HOST_W-1:0]   out_host;
    logic [CAP_W-1:0]    live_total;
  } rsp_t;

endpackage

`default_nettype wire

>>> hdl/cht_if.sv
// Valid/ready channel interfaces for command and result words.
// Depends on cht_pkg for the payload structs.
`default_nettype none

interface cht_cmd_if;
  import cht_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cht_rsp_if;
  import cht_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/cht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; a read of the address being written returns the old data.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/capability_handle_table_unit.sv
// Capability handle table with bump-allocated handles, not reused until the table is emptied.
// Depends on cht_pkg, the channel interfaces in cht_if.sv and cht_ram.
//
// Usage: command words arrive on the cmd channel and each one produces exactly
// one result word on the rsp channel, in order. A word is taken at a rising
// edge where valid and ready are both high. Allocate stores the type, rights
// and host tag at the next slot and returns its handle, lookup returns the
// stored fields of a live handle, revoke kills a live handle and count returns
// the number of live entries. Writing the capacity register through cfg_we and
// cfg_data empties the table; it must only be written while the block is idle.
//
// Timing: a taken command enters the working stage; its result is registered
// in the result register and presented from then on. The block takes one
// command per cycle while rsp is not stalled; that rate is set by the single
// read port of the mark and data RAMs, read as the command is taken and used
// in the next cycle with a one-entry bypass of the write made meanwhile.
//
// Reset: capacity returns to 256 and both counters to zero. No clearing pass
// is needed: a slot counts as live only below the allocation pointer, and
// every such slot was written since the last clear.
//
// Backpressure: when rsp is stalled the finished result waits in the output
// register, one more command waits in the working stage, and cmd ready drops.
`default_nettype none

module capability_handle_table_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int HOST_WIDTH  = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [cht_pkg::CAP_W-1:0] cfg_data,
  cht_cmd_if.sink                      cmd,
  cht_rsp_if.source                    rsp
);

  import cht_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW      = 2 * WORD_W + HOST_WIDTH;
  localparam int DEPTH_C = (TABLE_DEPTH > int'(CAP_MAX)) ? int'(CAP_MAX) : TABLE_DEPTH;
  localparam logic [CAP_W-1:0] DEPTH_LIM = CAP_W'(DEPTH_C);

  // Configuration and counters.
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] next_slot;
  logic [CAP_W-1:0] live_count;
  logic [CAP_W-1:0] usable;

  // Working stage: the command whose RAM reads are in flight.
  logic s1_valid;
  cmd_t s1;
  logic s1_fire;
  logic in_fire;

  // Result register.
  logic out_valid;
  rsp_t out_data;
  rsp_t rsp_next;

  // RAM ports.
  logic          mark_we;
  logic [AW-1:0] mark_waddr;
  logic          mark_wdata;
  logic          mark_rd;
  logic          data_we;
  logic [DW-1:0] data_wdata;
  logic [DW-1:0] data_rd;

  // Bypass of the write made in the cycle the working command was read.
  logic          fwd_we;
  logic          fwd_alloc;
  logic [AW-1:0] fwd_addr;
  logic          fwd_mark;
  logic [DW-1:0] fwd_data;

  // Decode of the working command.
  logic          fwd_hit;
  logic          mark_cur;
  logic [DW-1:0] data_cur;
  logic [AW-1:0] h_idx;
  logic          h_live;
  logic          full;
  logic          alloc_ok;
  logic          revoke_ok;

  assign usable  = (capacity > DEPTH_LIM) ? DEPTH_LIM : capacity;
  assign s1_fire = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_fire;
  assign in_fire = cmd.valid && cmd.ready;

  assign h_idx    = AW'(s1.handle);
  assign fwd_hit  = fwd_we && (fwd_addr == h_idx);
  assign mark_cur = fwd_hit ? fwd_mark : mark_rd;
  assign data_cur = (fwd_hit && fwd_alloc) ? fwd_data : data_rd;

  // Every slot below next_slot was written since the last clear, and
  // next_slot never passes the usable capacity.
  assign h_live    = (s1.handle < HANDLE_W'(next_slot)) && mark_cur;
  assign full      = next_slot >= usable;
  assign alloc_ok  = (s1.op == OP_ALLOC) && !full;
  assign revoke_ok = (s1.op == OP_REVOKE) && h_live;

  assign mark_we    = s1_fire && (alloc_ok || revoke_ok);
  assign mark_waddr = alloc_ok ? AW'(next_slot) : h_idx;
  assign mark_wdata = alloc_ok;
  assign data_we    = s1_fire && alloc_ok;
  assign data_wdata = {s1.entry_type, s1.entry_rights, s1.host_tag[HOST_WIDTH-1:0]};

  cht_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (in_fire),
    .raddr (AW'(cmd.data.handle)),
    .rdata (mark_rd)
  );

  cht_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (AW'(next_slot)),
    .wdata (data_wdata),
    .re    (in_fire),
    .raddr (AW'(cmd.data.handle)),
    .rdata (data_rd)
  );

  // Result word for the working command.
  always_comb begin
    rsp_next            = '0;
    rsp_next.status     = ST_OK;
    case (s1.op)
      OP_ALLOC: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.out_handle = OUTH_W'(next_slot);
        end
      end
      OP_LOOKUP: begin
        if (!h_live) begin
          rsp_next.status = ST_BAD;
        end else begin
          rsp_next.out_type   = data_cur[DW-1 -: WORD_W];
          rsp_next.out_rights = data_cur[DW-WORD_W-1 -: WORD_W];
          rsp_next.out_host   = HOST_W'(data_cur[HOST_WIDTH-1:0]);
        end
      end
      OP_REVOKE: begin
        if (!h_live) begin
          rsp_next.status = ST_BAD;
        end
      end
      OP_COUNT: begin
        rsp_next.live_total = live_count;
      end
      default: begin
        rsp_next.status = ST_BAD;
      end
    endcase
  end

  // Capacity register and counters. A capacity write empties the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      next_slot  <= '0;
      live_count <= '0;
    end else if (cfg_we) begin
      capacity   <= cfg_data;
      next_slot  <= '0;
      live_count <= '0;
    end else if (s1_fire) begin
      if (alloc_ok) begin
        next_slot  <= next_slot + 1'b1;
        live_count <= live_count + 1'b1;
      end else if (revoke_ok) begin
        live_count <= live_count - 1'b1;
      end
    end
  end

  // Working stage and bypass capture. The bypass records the write made in
  // the same cycle the new command reads the RAMs, since that read sees old
  // data. While the command waits here nothing else writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_we   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd_we   <= mark_we;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1        <= cmd.data;
      fwd_alloc <= data_we;
      fwd_addr  <= mark_waddr;
      fwd_mark  <= mark_wdata;
      fwd_data  <= data_wdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= rsp_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`ifndef SYNTH
  // Live entries are a subset of the slots handed out.
  a_live_le_next: assert property (@(posedge clk) disable iff (rst)
    live_count <= next_slot)
    else $error("live count exceeds allocation pointer");

  // The allocation pointer never passes the usable capacity.
  a_next_le_usable: assert property (@(posedge clk) disable iff (rst)
    next_slot <= usable)
    else $error("allocation pointer beyond usable capacity");

  // A successful allocate bumps the pointer by exactly one.
  a_alloc_bump: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && alloc_ok && !cfg_we) |=> (next_slot == $past(next_slot) + 1'b1))
    else $error("allocate did not advance the pointer");

  // Input is held back only when both stages are occupied and the output stalls.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && out_valid && !rsp.ready))
    else $error("command stalled without a full pipeline");
`endif

endmodule

`default_nettype wire
